### rtl/core/i2c_rm_pkg.sv
`default_nettype none

package i2c_rm_pkg;

    // Widths of the bus sequencer state
    localparam int StepW  = 4;
    localparam int BitW   = 4;
    localparam int SubW   = 3;
    localparam int HoldW  = 16;

    // Segment kinds of a transfer plan
    typedef enum logic [3:0] {
        KIND_START = 4'd0,
        KIND_DEVW  = 4'd1,
        KIND_DEVR  = 4'd2,
        KIND_REG   = 4'd3,
        KIND_DATA  = 4'd4,
        KIND_ACK0  = 4'd5,
        KIND_ACK1  = 4'd6,
        KIND_ACK2  = 4'd7,
        KIND_ACK2R = 4'd8,
        KIND_RECV  = 4'd9,
        KIND_NACK  = 4'd10,
        KIND_STOP  = 4'd11
    } kind_t;

    // Operation selector
    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_READ  = 1'b1
    } func_t;

    // One tick beat as seen by the sequencer
    typedef struct packed {
        logic       start_req;
        logic       func;
        logic [6:0] dev_address;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       sda_in;
    } tick_t;

    // Latched command
    typedef struct packed {
        logic       func;
        logic [6:0] dev_address;
        logic [7:0] reg_address;
        logic [7:0] write_data;
    } cmd_t;

    // One result beat
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [2:0] ack_bits;
    } res_t;

    localparam logic [StepW-1:0] WritePlanLen = StepW'(8);
    localparam logic [StepW-1:0] ReadPlanLen  = StepW'(11);

    // Segment at a given plan position
    function automatic kind_t plan_kind(input logic is_read, input logic [StepW-1:0] step);
        kind_t k;
        k = KIND_STOP;
        if (is_read) begin
            unique case (step)
                4'd0:    k = KIND_START;
                4'd1:    k = KIND_DEVW;
                4'd2:    k = KIND_ACK0;
                4'd3:    k = KIND_REG;
                4'd4:    k = KIND_ACK1;
                4'd5:    k = KIND_START;
                4'd6:    k = KIND_DEVR;
                4'd7:    k = KIND_ACK2R;
                4'd8:    k = KIND_RECV;
                4'd9:    k = KIND_NACK;
                default: k = KIND_STOP;
            endcase
        end
        else begin
            unique case (step)
                4'd0:    k = KIND_START;
                4'd1:    k = KIND_DEVW;
                4'd2:    k = KIND_ACK0;
                4'd3:    k = KIND_REG;
                4'd4:    k = KIND_ACK1;
                4'd5:    k = KIND_DATA;
                4'd6:    k = KIND_ACK2;
                default: k = KIND_STOP;
            endcase
        end
        return k;
    endfunction

    function automatic logic is_byte_kind(input kind_t k);
        return (k == KIND_DEVW) || (k == KIND_DEVR) || (k == KIND_REG) || (k == KIND_DATA);
    endfunction

    // Number of line phases in one bit of a segment
    function automatic logic [SubW-1:0] subs_of(input kind_t k);
        logic [SubW-1:0] n;
        unique case (k)
            KIND_DEVW, KIND_DEVR, KIND_REG, KIND_DATA: n = 3'd4;
            KIND_RECV, KIND_START:                     n = 3'd3;
            KIND_NACK:                                 n = 3'd4;
            KIND_STOP:                                 n = 3'd2;
            default:                                   n = 3'd5;
        endcase
        return n;
    endfunction

    // Number of bits in a segment
    function automatic logic [BitW-1:0] bits_of(input kind_t k);
        return (is_byte_kind(k) || (k == KIND_RECV)) ? BitW'(8) : BitW'(1);
    endfunction

endpackage

`default_nettype wire

### rtl/core/i2c_rm_if.sv
`default_nettype none

// Tick channel
interface i2c_rm_tick_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic       func;
    logic [6:0] dev_address;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, start_req, func, dev_address, reg_address, write_data,
                    sda_in, input ready);
    modport sink   (input valid, start_req, func, dev_address, reg_address, write_data,
                    sda_in, output ready);
endinterface

// Result channel
interface i2c_rm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [2:0] ack_bits;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data, ack_bits,
                    input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data, ack_bits,
                    output ready);
endinterface

// Configuration write channel
interface i2c_rm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] phase_ticks;

    modport source (output valid, phase_ticks, input ready);
    modport sink   (input valid, phase_ticks, output ready);
endinterface

`default_nettype wire

### rtl/core/i2c_rm_seq.sv
`default_nettype none

module i2c_rm_seq
    import i2c_rm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  tick_t       tick,
    input  logic [15:0] phase_ticks,
    output res_t        res
);

    logic             active_reg,   active_next;
    logic [StepW-1:0] step_reg,     step_next;
    logic [BitW-1:0]  bit_reg,      bit_next;
    logic [SubW-1:0]  sub_reg,      sub_next;
    logic [HoldW-1:0] hold_reg,     hold_next;
    logic [7:0]       shift_reg,    shift_next;
    cmd_t             cmd_reg,      cmd_next;
    logic [7:0]       rx_reg,       rx_next;
    logic [2:0]       ack_reg,      ack_next;
    logic             scl_reg,      scl_next;
    logic             sda_reg,      sda_next;
    logic             done;
    logic             busy;
    kind_t            kind;
    logic [HoldW-1:0] hold_inc;
    logic [HoldW-1:0] limit;
    logic [StepW-1:0] plan_len;

    // One tick of the bus sequencer
    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        bit_next    = bit_reg;
        sub_next    = sub_reg;
        hold_next   = hold_reg;
        shift_next  = shift_reg;
        cmd_next    = cmd_reg;
        rx_next     = rx_reg;
        ack_next    = ack_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        done        = 1'b0;
        busy        = 1'b0;
        kind        = KIND_STOP;
        hold_inc    = '0;
        limit       = (phase_ticks == '0) ? HoldW'(1) : phase_ticks;
        plan_len    = WritePlanLen;

        // launch a transfer when idle
        if (!active_reg && tick.start_req)
        begin
            cmd_next.func        = tick.func;
            cmd_next.dev_address = tick.dev_address;
            cmd_next.reg_address = tick.reg_address;
            cmd_next.write_data  = tick.write_data;
            active_next = 1'b1;
            step_next   = '0;
            bit_next    = '0;
            sub_next    = '0;
            hold_next   = '0;
            ack_next    = '0;
        end

        if (active_next)
        begin
            busy     = 1'b1;
            kind     = plan_kind(cmd_next.func, step_next);
            plan_len = (cmd_next.func == FUNC_READ) ? ReadPlanLen : WritePlanLen;

            // line changes and samples on the first tick of a phase
            if (hold_next == '0)
            begin
                unique case (kind)
                    KIND_START:
                    begin
                        if (sub_next == 3'd0)
                        begin
                            scl_next = 1'b1;
                            sda_next = 1'b1;
                        end
                        else if (sub_next == 3'd1)
                            sda_next = 1'b0;
                        else
                            scl_next = 1'b0;
                    end
                    KIND_DEVW, KIND_DEVR, KIND_REG, KIND_DATA:
                    begin
                        if (bit_next == '0 && sub_next == 3'd0)
                        begin
                            unique case (kind)
                                KIND_DEVW: shift_next = {cmd_next.dev_address, 1'b0};
                                KIND_DEVR: shift_next = {cmd_next.dev_address, 1'b1};
                                KIND_REG:  shift_next = cmd_next.reg_address;
                                default:   shift_next = cmd_next.write_data;
                            endcase
                        end
                        if (sub_next == 3'd0)
                            sda_next = shift_next[3'd7 - bit_next[2:0]];
                        else if (sub_next == 3'd1)
                            scl_next = 1'b1;
                        else if (sub_next == 3'd2)
                            scl_next = 1'b0;
                        else
                            sda_next = 1'b0;
                    end
                    KIND_RECV:
                    begin
                        if (sub_next == 3'd0)
                        begin
                            if (bit_next == '0)
                                shift_next = '0;
                            scl_next = 1'b1;
                        end
                        else if (sub_next == 3'd1)
                            shift_next = {shift_next[6:0], tick.sda_in};
                        else
                            scl_next = 1'b0;
                    end
                    KIND_NACK:
                    begin
                        if (sub_next == 3'd0)
                            sda_next = 1'b1;
                        else if (sub_next == 3'd1)
                            scl_next = 1'b1;
                        else if (sub_next == 3'd2)
                            scl_next = 1'b0;
                        else
                            sda_next = 1'b0;
                    end
                    KIND_STOP:
                    begin
                        if (sub_next == 3'd0)
                            scl_next = 1'b1;
                        else
                            sda_next = 1'b1;
                    end
                    default:
                    begin
                        // acknowledge slot
                        if (sub_next == 3'd0)
                            sda_next = 1'b1;
                        else if (sub_next == 3'd1)
                            scl_next = 1'b1;
                        else if (sub_next == 3'd2)
                        begin
                            if (!tick.sda_in)
                            begin
                                if (kind == KIND_ACK0)
                                    ack_next[0] = 1'b1;
                                else if (kind == KIND_ACK1)
                                    ack_next[1] = 1'b1;
                                else
                                    ack_next[2] = 1'b1;
                            end
                        end
                        else if (sub_next == 3'd3)
                            scl_next = 1'b0;
                        else
                            sda_next = (kind == KIND_ACK2R);
                    end
                endcase
            end

            // phase, bit and segment counters
            hold_inc  = hold_next + HoldW'(1);
            hold_next = hold_inc;
            if (hold_inc >= limit)
            begin
                hold_next = '0;
                sub_next  = sub_next + SubW'(1);
                if (sub_next >= subs_of(kind))
                begin
                    sub_next = '0;
                    bit_next = bit_next + BitW'(1);
                    if (bit_next >= bits_of(kind))
                    begin
                        bit_next  = '0;
                        step_next = step_next + StepW'(1);
                        if (step_next >= plan_len)
                        begin
                            if (cmd_next.func == FUNC_READ)
                                rx_next = shift_next;
                            step_next   = '0;
                            active_next = 1'b0;
                            done        = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Result of this tick
    always_comb
    begin
        res.scl_out   = scl_next;
        res.sda_out   = sda_next;
        res.busy_res  = busy;
        res.done_res  = done;
        res.read_data = rx_next;
        res.ack_bits  = ack_next;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
            bit_reg    <= '0;
            sub_reg    <= '0;
            hold_reg   <= '0;
            shift_reg  <= '0;
            cmd_reg    <= '0;
            rx_reg     <= '0;
            ack_reg    <= '0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
        end
        else if (step_en)
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
            bit_reg    <= bit_next;
            sub_reg    <= sub_next;
            hold_reg   <= hold_next;
            shift_reg  <= shift_next;
            cmd_reg    <= cmd_next;
            rx_reg     <= rx_next;
            ack_reg    <= ack_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/i2c_rm_out_stage.sv
`default_nettype none

module i2c_rm_out_stage
    import i2c_rm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_res,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic valid_reg, valid_next;
    res_t res_reg,   res_next;

    // Space when empty or when the held beat leaves this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            res_next   = in_res;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

### rtl/core/i2c_register_master.sv
`default_nettype none

// Channel   Role  Beat carries
// tick      sink  start_req, func, dev_address, reg_address, write_data, sda_in
// result    src   scl_out, sda_out, busy_res, done_res, read_data, ack_bits
// cfg       sink  phase_ticks (always ready)
//
// One tick beat is taken per clock while the result register has room; its result beat
// is registered and offered the next cycle. The sequencer step is a single combinational
// pass from state registers into the result register. A stalled result holds the tick
// channel off only while the result register is full and not being taken. Reset leaves
// the sequencer idle, both lines high, phase_ticks 1.

module i2c_register_master
    import i2c_rm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    i2c_rm_tick_if.sink  tick,
    i2c_rm_res_if.source result,
    i2c_rm_cfg_if.sink   cfg
);

    logic        cfg_write;
    logic [15:0] phase_reg;
    logic        take;
    logic        stage_ready;
    tick_t       tick_beat;
    res_t        step_res;
    res_t        out_res;

    // Phase length register
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 16'd1;
        else if (cfg_write)
            phase_reg <= cfg.phase_ticks;
    end

    // Tick beat
    always_comb
    begin
        tick_beat.start_req   = tick.start_req;
        tick_beat.func        = tick.func;
        tick_beat.dev_address = tick.dev_address;
        tick_beat.reg_address = tick.reg_address;
        tick_beat.write_data  = tick.write_data;
        tick_beat.sda_in      = tick.sda_in;
    end

    assign tick.ready = stage_ready;
    assign take       = tick.valid && stage_ready;

    i2c_rm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (take),
        .tick        (tick_beat),
        .phase_ticks (phase_reg),
        .res         (step_res)
    );

    i2c_rm_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (stage_ready),
        .in_res    (step_res),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_res   (out_res)
    );

    assign result.scl_out   = out_res.scl_out;
    assign result.sda_out   = out_res.sda_out;
    assign result.busy_res  = out_res.busy_res;
    assign result.done_res  = out_res.done_res;
    assign result.read_data = out_res.read_data;
    assign result.ack_bits  = out_res.ack_bits;

endmodule

`default_nettype wire
